### design/cstr_pkg.sv
// Shared constants for the count-smaller-to-right unit.
// Fixed result field widths; no dependencies.
`default_nettype none

package cstr_pkg;

    // Width of the position field of a result
    localparam int unsigned POSITION_W = 6;

    // Width of the smaller-count field of a result
    localparam int unsigned SMALLER_W = 6;

endpackage

`default_nettype wire

### design/count_smaller_to_right_unit.sv
// Count-smaller-to-right unit: top level, sequencer, value memory and compare unit.
// Depends on cstr_pkg for the result field widths.
`default_nettype none

// Values stream in one per cycle and are stored in arrival order; the transfer
// flagged last closes the set. Values past MAX_N are dropped and every result of
// that set carries truncated. After the set is closed, the block walks each
// position i, reads its value as the key, then streams the later entries through
// one signed comparator, one entry per cycle, and counts the strictly smaller
// ones. One result per position is emitted in original order, the final one
// with last_result set. Each position passes through ST_KEY, ST_KEY_CAP,
// ST_SCAN and ST_OUT in order, with the single memory read port feeding the
// comparator; the result channel can hold ST_OUT. s_ready is low for the
// whole closing phase.
module count_smaller_to_right_unit #(
    parameter int unsigned MAX_N       = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // input channel
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  signed [VALUE_WIDTH-1:0]       s_value,
    input  wire                                 s_last,
    // result channel
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [cstr_pkg::POSITION_W-1:0]     m_position,
    output logic [cstr_pkg::SMALLER_W-1:0]      m_smaller_count,
    output logic                                m_last_result,
    output logic                                m_truncated
);

    localparam int unsigned IDX_W = $clog2(MAX_N);
    localparam int unsigned CNT_W = $clog2(MAX_N + 1);
    localparam logic [CNT_W-1:0] MAX_N_C = CNT_W'(MAX_N);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_KEY_CAP,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               loaded_reg, loaded_next;
    logic                           overflow_reg, overflow_next;
    logic [CNT_W-1:0]               i_reg, i_next;
    logic [CNT_W-1:0]               j_reg, j_next;
    logic [IDX_W-1:0]               cnt_reg, cnt_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic signed [VALUE_WIDTH-1:0]  key_reg, key_next;

    logic [VALUE_WIDTH-1:0]         value_mem [MAX_N];
    logic signed [VALUE_WIDTH-1:0]  rd_data_reg;
    logic [IDX_W-1:0]               rd_addr;
    logic                           wr_en;
    logic                           in_xfer;
    logic                           out_xfer;
    logic                           is_final;
    logic                           smaller;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign wr_en    = in_xfer && (loaded_reg < MAX_N_C);
    assign is_final = ((i_reg + ONE_C) == loaded_reg);
    assign smaller  = (rd_data_reg < key_reg);

    // Select the read address: the key in ST_KEY, the scan pointer otherwise
    always_comb begin
        if (state_reg == ST_KEY) begin
            rd_addr = i_reg[IDX_W-1:0];
        end else begin
            rd_addr = j_reg[IDX_W-1:0];
        end
    end

    // Value memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[loaded_reg[IDX_W-1:0]] <= s_value;
        end
        rd_data_reg <= $signed(value_mem[rd_addr]);
    end

    // Sequencer next-state logic
    always_comb begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        overflow_next  = overflow_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        cmp_valid_next = 1'b0;
        key_next       = key_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (loaded_reg < MAX_N_C) begin
                        loaded_next = loaded_reg + ONE_C;
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_last) begin
                        i_next     = '0;
                        state_next = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                state_next = ST_KEY_CAP;
            end
            ST_KEY_CAP: begin
                // capture the key, start the scan right after it
                key_next   = rd_data_reg;
                cnt_next   = '0;
                j_next     = i_reg + ONE_C;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // count the entry read last cycle
                if (cmp_valid_reg && smaller) begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
                // issue the next read, or finish
                if (j_reg < loaded_reg) begin
                    j_next         = j_reg + ONE_C;
                    cmp_valid_next = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    if (is_final) begin
                        loaded_next   = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_LOAD;
                    end else begin
                        i_next     = i_reg + ONE_C;
                        state_next = ST_KEY;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            loaded_reg    <= '0;
            overflow_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            overflow_reg  <= overflow_next;
            cmp_valid_reg <= cmp_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
        end
        key_reg <= key_next;
    end

    // Drive the channels
    assign s_ready         = (state_reg == ST_LOAD);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_position      = cstr_pkg::POSITION_W'(i_reg[IDX_W-1:0]);
    assign m_smaller_count = cstr_pkg::SMALLER_W'(cnt_reg);
    assign m_last_result   = is_final;
    assign m_truncated     = overflow_reg;

    // The final position has no later elements to count
    a_final_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_result) |-> (m_smaller_count == '0))
        else $error("final result has a nonzero count");

    // A count never exceeds the number of later elements
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((CNT_W'(cnt_reg) + i_reg) < loaded_reg))
        else $error("count exceeds later elements");

    // The fill count stays within capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= MAX_N_C)
        else $error("fill count beyond capacity");

    // Loading and emitting never overlap
    a_phase_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is offered");

endmodule

`default_nettype wire
